[sv/skel_pkg.sv]
// ----------------------------------------------------------------------------
// skel_pkg
// Shared types and codes for the sorted key extent lookup block.
// ----------------------------------------------------------------------------
package skel_pkg;

	localparam int KEY_W   = 64;
	localparam int EXT_W   = 48;
	localparam int IDX_W   = 10;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_ASCND = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [KEY_W-1:0] search_key;
		logic [EXT_W-1:0] extent_end;
	} cmd_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  entry_index;
		logic [EXT_W-1:0]  start_offset;
		logic [EXT_W-1:0]  extent_length;
		logic [STAT_W-1:0] status;
	} res_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ISSUE = 6'b000010,
		ST_CMP   = 6'b000100,
		ST_PREV  = 6'b001000,
		ST_CUR   = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

endpackage

[sv/skel_ram.sv]
// ----------------------------------------------------------------------------
// skel_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module skel_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/skel_ctrl.sv]
// ----------------------------------------------------------------------------
// skel_ctrl
// Command sequencer: clear/append bookkeeping, range check, binary search
// over the key RAM and extent fetch from the end RAM, plus the result register.
// ----------------------------------------------------------------------------
module skel_ctrl import skel_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	output logic                 key_we,
	output logic [AW-1:0]        key_waddr,
	output logic [KEY_WIDTH-1:0] key_wdata,
	output logic [AW-1:0]        key_raddr,
	input  logic [KEY_WIDTH-1:0] key_rdata,
	output logic                 end_we,
	output logic [AW-1:0]        end_waddr,
	output logic [EXT_W-1:0]     end_wdata,
	output logic [AW-1:0]        end_raddr,
	input  logic [EXT_W-1:0]     end_rdata
);

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [KEY_WIDTH-1:0] first_key_q;
	logic [KEY_WIDTH-1:0] last_key_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [CW-1:0]        mid_q;
	logic [EXT_W-1:0]     start_q;
	res_t                 res_q;
	res_t                 out_q;
	logic                 out_valid_q;

	logic                 accept;
	logic [KEY_WIDTH-1:0] cmd_key;
	logic                 app_full;
	logic                 app_order;
	logic                 app_ok;
	logic                 range_miss;
	logic [CW-1:0]        mid_c;
	logic                 out_free;
	logic [AW+IDX_W-1:0]  mid_ext;

	assign cmd_stall  = (state_q != ST_IDLE);
	assign accept     = cmd_valid && (state_q == ST_IDLE);
	assign cmd_key    = cmd.search_key[KEY_WIDTH-1:0];
	assign app_full   = (count_q == CW'(TABLE_DEPTH));
	assign app_order  = (count_q != '0) && (cmd_key <= last_key_q);
	assign app_ok     = !app_full && !app_order;
	assign range_miss = (count_q == '0) || (cmd_key < first_key_q) || (cmd_key > last_key_q);
	assign mid_c      = lo_q + ((hi_q - lo_q) >> 1);
	assign out_free   = !out_valid_q || !res_stall;
	assign mid_ext    = {{IDX_W{1'b0}}, mid_q[AW-1:0]};

	assign key_we    = accept && (cmd.opcode == OP_APPEND) && app_ok;
	assign key_waddr = count_q[AW-1:0];
	assign key_wdata = cmd_key;
	assign key_raddr = mid_c[AW-1:0];
	assign end_we    = key_we;
	assign end_waddr = count_q[AW-1:0];
	assign end_wdata = cmd.extent_end;

	// previous end is fetched first unless the hit is entry zero
	always_comb begin
		end_raddr = mid_q[AW-1:0];
		if (state_q == ST_CMP && mid_q != '0) begin
			end_raddr = mid_q[AW-1:0] - AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.opcode == OP_LOOKUP && !range_miss) begin
							state_q <= ST_ISSUE;
						end else begin
							state_q <= ST_RESP;
						end
						if (cmd.opcode == OP_CLEAR) begin
							count_q <= '0;
						end else if (key_we) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_ISSUE: begin
					state_q <= (lo_q < hi_q) ? ST_CMP : ST_RESP;
				end
				ST_CMP: begin
					if (key_rdata == key_q) begin
						state_q <= (mid_q == '0) ? ST_CUR : ST_PREV;
					end else begin
						state_q <= ST_ISSUE;
					end
				end
				ST_PREV: state_q <= ST_CUR;
				ST_CUR:  state_q <= ST_RESP;
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q <= cmd_key;
					lo_q  <= '0;
					hi_q  <= count_q;
					res_q <= '0;
					if (cmd.opcode == OP_APPEND) begin
						if (app_full) begin
							res_q.status <= STAT_FULL;
						end else if (app_order) begin
							res_q.status <= STAT_NOT_ASCND;
						end else begin
							last_key_q <= cmd_key;
							if (count_q == '0) begin
								first_key_q <= cmd_key;
							end
						end
					end
				end
			end
			ST_ISSUE: mid_q <= mid_c;
			ST_CMP: begin
				if (key_rdata == key_q) begin
					start_q <= '0;
				end else if (key_rdata < key_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_PREV: start_q <= end_rdata;
			ST_CUR: begin
				res_q.found         <= 1'b1;
				res_q.entry_index   <= mid_ext[IDX_W-1:0];
				res_q.start_offset  <= start_q;
				res_q.extent_length <= end_rdata - start_q;
			end
			ST_RESP: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (lo_q <= hi_q && hi_q <= count_q))
		else $error("search window out of bounds");

	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (cmd_valid && !cmd_stall && cmd.opcode == OP_APPEND))
		else $error("table write without an append transfer");

	a_resp_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && out_free) |=> (res_valid && state_q == ST_IDLE))
		else $error("result not presented after completion");
`endif

endmodule

[sv/sorted_key_extent_lookup.sv]
// ----------------------------------------------------------------------------
// sorted_key_extent_lookup
// Sorted key table with per-entry extent ends; clear, append and lookup.
// ----------------------------------------------------------------------------
// Clear and append: the command is taken in IDLE, then RESP loads the result register.
// Lookup: each binary search step on the key RAM read port runs ISSUE then CMP, up to
// ceil(log2(count+1)) steps, then end RAM reads in PREV (skipped for entry zero) and
// CUR, then RESP; a range reject goes straight from IDLE to RESP.
// One command at a time; the next is taken while the result waits.
// Reset clears the entry count and control; RAM contents are not cleared.
module sorted_key_extent_lookup import skel_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                 key_we;
	logic [AW-1:0]        key_waddr;
	logic [KEY_WIDTH-1:0] key_wdata;
	logic [AW-1:0]        key_raddr;
	logic [KEY_WIDTH-1:0] key_rdata;
	logic                 end_we;
	logic [AW-1:0]        end_waddr;
	logic [EXT_W-1:0]     end_wdata;
	logic [AW-1:0]        end_raddr;
	logic [EXT_W-1:0]     end_rdata;

	skel_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	skel_ram #(.WIDTH(EXT_W), .DEPTH(TABLE_DEPTH)) u_end_ram (
		.clk   (clk),
		.we    (end_we),
		.waddr (end_waddr),
		.wdata (end_wdata),
		.raddr (end_raddr),
		.rdata (end_rdata)
	);

	skel_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.key_we    (key_we),
		.key_waddr (key_waddr),
		.key_wdata (key_wdata),
		.key_raddr (key_raddr),
		.key_rdata (key_rdata),
		.end_we    (end_we),
		.end_waddr (end_waddr),
		.end_wdata (end_wdata),
		.end_raddr (end_raddr),
		.end_rdata (end_rdata)
	);

endmodule

[test/extent_lookup_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// extent_lookup_checker
// Watches the command and reply channels of the extent lookup block, keeps its
// own copy of the key and extent tables, predicts every reply and compares
// replies with the predictions in order, field by field.
// ----------------------------------------------------------------------------
module extent_lookup_checker import skel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   mismatches,
	output int   pending
);

	localparam int DEPTH = 1024;

	logic [KEY_W-1:0] key_copy [DEPTH];
	logic [EXT_W-1:0] end_copy [DEPTH];
	int               entries;
	res_t             replies_due [$];
	res_t             want;

	// Next reply for one command; updates the table copy as the block would.
	function automatic res_t apply_command(input cmd_t c);
		res_t r;
		int   lo;
		int   hi;
		int   mid;
		int   pos;
		bit   hit;
		r = '0;
		case (c.opcode)
		OP_CLEAR: begin
			entries = 0;
		end
		OP_APPEND: begin
			if (entries >= DEPTH)
				r.status = STAT_FULL;
			else if (entries > 0 && c.search_key <= key_copy[entries-1])
				r.status = STAT_NOT_ASCND;
			else begin
				key_copy[entries] = c.search_key;
				end_copy[entries] = c.extent_end;
				entries++;
			end
		end
		OP_LOOKUP: begin
			hit = 1'b0;
			pos = 0;
			// range check on first and last key, then exact binary search
			if (entries > 0 && c.search_key >= key_copy[0] &&
					c.search_key <= key_copy[entries-1]) begin
				lo = 0;
				hi = entries;
				while (lo < hi && !hit) begin
					mid = lo + (hi - lo) / 2;
					if (key_copy[mid] == c.search_key) begin
						hit = 1'b1;
						pos = mid;
					end else if (key_copy[mid] < c.search_key)
						lo = mid + 1;
					else
						hi = mid;
				end
			end
			if (hit) begin
				r.found         = 1'b1;
				r.entry_index   = IDX_W'(pos);
				r.start_offset  = (pos == 0) ? '0 : end_copy[pos-1];
				r.extent_length = end_copy[pos] - r.start_offset;
			end
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries    = 0;
			mismatches = 0;
			replies_due.delete();
			pending    = 0;
		end else begin
			// a reply never belongs to a command taken at the same edge
			if (res_valid && !res_stall) begin
				if (replies_due.size() == 0) begin
					$error("reply transfer with no command outstanding: %p", res);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					compare_field("found", 64'(want.found), 64'(res.found));
					compare_field("entry_index", 64'(want.entry_index),
						64'(res.entry_index));
					compare_field("start_offset", 64'(want.start_offset),
						64'(res.start_offset));
					compare_field("extent_length", 64'(want.extent_length),
						64'(res.extent_length));
					compare_field("status", 64'(want.status), 64'(res.status));
				end
			end
			if (cmd_valid && !cmd_stall)
				replies_due = {replies_due, apply_command(cmd)};
			pending = replies_due.size();
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted key extent lookup block: directed corner cases, a
// table filled to capacity, then random clear / append / lookup sequences
// with random idle cycles on both channels and one long reply hold-off.
// ----------------------------------------------------------------------------
module tb import skel_pkg::*; ();

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int              DEPTH   = 1024;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	int   mismatches;
	int   pending;

	bit               steady   = 1'b0;
	bit               hold_req = 1'b0;
	int               sent     = 0;
	logic [KEY_W-1:0] stored_keys [$];

	sorted_key_extent_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	extent_lookup_checker reply_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [EXT_W-1:0] rand_end();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[EXT_W-1:0];
	endfunction

	// One command transfer; valid stays high into the next call unless it idles.
	task automatic transfer(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [EXT_W-1:0] ext);
		if (!steady) begin
			while ($urandom_range(99) < 26) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd       <= '{opcode: op, search_key: key, extent_end: ext};
		do @(negedge clk); while (cmd_stall);
		@(posedge clk);
		sent++;
	endtask

	// Keeps the list of stored keys so lookups can aim at hits and near misses.
	task automatic append_entry(input logic [KEY_W-1:0] key, input logic [EXT_W-1:0] ext);
		if (stored_keys.size() < DEPTH && (stored_keys.size() == 0 || key > stored_keys[$]))
			stored_keys = {stored_keys, key};
		transfer(OP_APPEND, key, ext);
	endtask

	task automatic clear_table();
		stored_keys.delete();
		transfer(OP_CLEAR, rand_key(), rand_end());
	endtask

	task automatic fill_table(input int n, input bit wide);
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] step;
		if (stored_keys.size() > 0)
			key = stored_keys[$] + 1;
		else if (wide)
			key = rand_key() >> $urandom_range(8);
		else
			key = KEY_W'($urandom_range(50));
		for (int i = 0; i < n; i++) begin
			append_entry(key, rand_end());
			step = wide ? {$urandom_range(255), $urandom} + 1 : KEY_W'($urandom_range(3, 1));
			if (key + step <= key)
				break;
			key += step;
		end
	endtask

	task automatic probe_table();
		int               n;
		int               pick;
		logic [KEY_W-1:0] key;
		n    = stored_keys.size();
		pick = $urandom_range(99);
		if (n == 0 || pick < 8)
			key = rand_key();
		else if (pick < 55)
			key = stored_keys[$urandom_range(n-1)];
		else if (pick < 72)
			key = stored_keys[$urandom_range(n-1)] + 1;
		else if (pick < 88)
			key = stored_keys[$urandom_range(n-1)] - 1;
		else if (pick < 94)
			key = stored_keys[0] - 1;
		else
			key = stored_keys[n-1] + 1;
		transfer(OP_LOOKUP, key, rand_end());
	endtask

	// Refused appends and no-op opcodes.
	task automatic send_noise();
		int n;
		n = stored_keys.size();
		if (n > 0 && $urandom_range(1))
			transfer(OP_APPEND, stored_keys[$urandom_range(n-1)], rand_end());
		else
			transfer(OP_NONE, rand_key(), rand_end());
	endtask

	// Reply side: random stalls, quiet while steady, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end else begin
				res_stall <= !steady && ($urandom_range(99) < 26);
			end
		end
	end

	initial begin
		bit held;
		int mode;
		int rounds;
		held = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, no-op opcode, equal and lower keys, wrapping length
		transfer(OP_LOOKUP, '0, rand_end());
		transfer(OP_LOOKUP, '1, '1);
		transfer(OP_NONE, '1, '1);
		append_entry('0, '0);
		append_entry('0, '1);
		transfer(OP_LOOKUP, '0, '0);
		append_entry(64'd5, '1);
		append_entry(64'd3, 48'h1);
		append_entry(64'd100, 48'h10);
		transfer(OP_LOOKUP, 64'd100, '0);
		transfer(OP_LOOKUP, 64'd5, '0);
		transfer(OP_LOOKUP, 64'd4, '0);
		append_entry('1, 48'h123);
		transfer(OP_LOOKUP, '1, '0);
		transfer(OP_LOOKUP, 64'd101, '0);
		transfer(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		append_entry('1, '0);
		clear_table();
		transfer(OP_LOOKUP, 64'd5, '0);
		append_entry(64'h8000_0000_0000_0000, 48'h8000_0000_0000);
		transfer(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0);
		transfer(OP_LOOKUP, 64'h8000_0000_0000_0001, '0);
		transfer(OP_LOOKUP, 64'h8000_0000_0000_0000, '0);

		// full table: refusal wins over key order, deepest searches
		clear_table();
		fill_table(DEPTH, 1'b0);
		append_entry('1, rand_end());
		append_entry('0, rand_end());
		transfer(OP_LOOKUP, stored_keys[0], '0);
		transfer(OP_LOOKUP, stored_keys[DEPTH-1], '0);
		transfer(OP_LOOKUP, stored_keys[DEPTH/2-1], '0);
		repeat (20) probe_table();

		sent = 0;
		while (sent < 700) begin
			steady = (sent > 150 && sent < 260);
			if (!held && sent > 400) begin
				hold_req = 1'b1;
				held     = 1'b1;
			end
			mode = $urandom_range(9);
			if (mode < 6 || stored_keys.size() == 0) begin
				clear_table();
				fill_table(mode == 0 ? $urandom_range(200, 25) : $urandom_range(24, 1),
					1'($urandom_range(1)));
			end else if (mode < 8) begin
				fill_table($urandom_range(8, 1), 1'($urandom_range(1)));
			end
			rounds = $urandom_range(30, 4);
			repeat (rounds) begin
				if ($urandom_range(99) < 12)
					send_noise();
				else
					probe_table();
			end
		end
		steady = 1'b0;
		cmd_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
